>>> rtl/core/determinant_4x4_core_macros.svh
// Assertion macros shared by the determinant core modules.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef DETERMINANT_4X4_CORE_MACROS_SVH
`define DETERMINANT_4X4_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DET4_ASSERT_IMP(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DET4_ASSERT_NXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/core/det4_pkg.sv
// Package for the 4x4 determinant core: sizes, shared types, term decoder.
// Depends on nothing.
package det4_pkg;

    localparam int ELEMENT_BITS_DEFAULT = 12;
    localparam int DET_BITS             = 50;
    localparam int ENTRIES              = 16;
    localparam int IDX_W                = $clog2(ENTRIES);
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [1:0] ROW_LAST  = 2'd3;
    localparam logic [2:0] TERM_LAST = 3'd5;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic first;
        logic last;
        logic neg;
    } term_flags_t;

    typedef struct packed {
        logic [IDX_W-1:0] e;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic             neg;
    } term_sel_t;

    // Entry indices and sign of one four-factor term: first-column entry of
    // 'row' times one diagonal product of its 3x3 minor (columns 1..3).
    function automatic term_sel_t term_select(input logic [1:0] row,
                                              input logic [2:0] term);
        logic [1:0] k0;
        logic [1:0] k1;
        logic [1:0] k2;
        term_sel_t  sel;
        unique case (row)
            2'd0:    begin k0 = 2'd1; k1 = 2'd2; k2 = 2'd3; end
            2'd1:    begin k0 = 2'd0; k1 = 2'd2; k2 = 2'd3; end
            2'd2:    begin k0 = 2'd0; k1 = 2'd1; k2 = 2'd3; end
            default: begin k0 = 2'd0; k1 = 2'd1; k2 = 2'd2; end
        endcase
        sel.e = {row, 2'd0};
        unique case (term)
            3'd1:
            begin
                sel.a = {k0, 2'd2}; sel.b = {k1, 2'd3}; sel.c = {k2, 2'd1}; sel.neg = 1'b0;
            end
            3'd2:
            begin
                sel.a = {k0, 2'd3}; sel.b = {k1, 2'd1}; sel.c = {k2, 2'd2}; sel.neg = 1'b0;
            end
            3'd3:
            begin
                sel.a = {k2, 2'd1}; sel.b = {k1, 2'd2}; sel.c = {k0, 2'd3}; sel.neg = 1'b1;
            end
            3'd4:
            begin
                sel.a = {k2, 2'd2}; sel.b = {k1, 2'd3}; sel.c = {k0, 2'd1}; sel.neg = 1'b1;
            end
            3'd5:
            begin
                sel.a = {k2, 2'd3}; sel.b = {k1, 2'd1}; sel.c = {k0, 2'd2}; sel.neg = 1'b1;
            end
            default:
            begin
                sel.a = {k0, 2'd1}; sel.b = {k1, 2'd2}; sel.c = {k2, 2'd3}; sel.neg = 1'b0;
            end
        endcase
        // odd rows of the first column carry a minus sign
        sel.neg = sel.neg ^ row[0];
        return sel;
    endfunction

endpackage

>>> rtl/core/det4_front.sv
// Front end: takes matrix words, gathers sixteen into a shift line, hands
// the full matrix to the queue. Depends on det4_pkg.
module det4_front #(
    parameter int ELEMENT_BITS = det4_pkg::ELEMENT_BITS_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic signed [ELEMENT_BITS-1:0]              element,
    input  det4_pkg::q_stat_t                           q_stat,
    output logic                                        q_push,
    output logic [det4_pkg::ENTRIES*ELEMENT_BITS-1:0]   q_data
);
    import det4_pkg::*;

    localparam int MAT_W = ENTRIES * ELEMENT_BITS;
    localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(ENTRIES - 1);

    logic [IDX_W-1:0] count_reg;
    logic [IDX_W-1:0] count_next;
    logic [MAT_W-1:0] shift_reg;
    logic [MAT_W-1:0] shift_next;
    logic             accept;
    logic             last_word;

    assign last_word = (count_reg == CNT_LAST);
    // stall only when the closing word has nowhere to go
    assign busy   = last_word && q_stat.full;
    assign accept = start && !busy;

    // entry 0 ends up in the lowest bits
    assign shift_next = accept ? {element, shift_reg[MAT_W-1:ELEMENT_BITS]} : shift_reg;
    assign q_data     = {element, shift_reg[MAT_W-1:ELEMENT_BITS]};
    assign q_push     = accept && last_word;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = last_word ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

>>> rtl/core/det4_queue.sv
// Two-slot queue of whole matrices between front and back end.
// Depends on det4_pkg and the assertion macro header.
`include "determinant_4x4_core_macros.svh"

module det4_queue #(
    parameter int ELEMENT_BITS = det4_pkg::ELEMENT_BITS_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        push,
    input  logic [det4_pkg::ENTRIES*ELEMENT_BITS-1:0]   data_in,
    input  logic                                        pop,
    output logic [det4_pkg::ENTRIES*ELEMENT_BITS-1:0]   head,
    output det4_pkg::q_stat_t                           stat
);
    import det4_pkg::*;

    localparam int MAT_W = ENTRIES * ELEMENT_BITS;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [MAT_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= data_in;
        end
    end

    `DET4_ASSERT_IMP(a_no_push_full, push, !stat.full || pop, "push into full matrix queue")
    `DET4_ASSERT_IMP(a_no_pop_empty, pop, !stat.empty, "pop from empty matrix queue")

endmodule

>>> rtl/core/det4_back.sv
// Back end: walks the 24 four-factor terms of one matrix through a chain of
// three registered multipliers and an accumulator. Depends on det4_pkg, macros.
`include "determinant_4x4_core_macros.svh"

module det4_back #(
    parameter int ELEMENT_BITS = det4_pkg::ELEMENT_BITS_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  det4_pkg::q_stat_t                           q_stat,
    input  logic [det4_pkg::ENTRIES*ELEMENT_BITS-1:0]   q_head,
    output logic                                        q_pop,
    output logic                                        done,
    output logic signed [det4_pkg::DET_BITS-1:0]        determinant
);
    import det4_pkg::*;

    localparam int EB      = ELEMENT_BITS;
    localparam int MAT_W   = ENTRIES * EB;
    localparam int ACC_RAW = 4 * EB + 5;
    localparam int ACC_W   = (ACC_RAW > DET_BITS) ? ACC_RAW : DET_BITS;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - DET_BITS + 1){1'b0}}, {(DET_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // sequencer
    back_state_t       state_reg;
    back_state_t       state_next;
    logic [1:0]        row_reg;
    logic [1:0]        row_next;
    logic [2:0]        term_reg;
    logic [2:0]        term_next;
    logic [MAT_W-1:0]  work_reg;
    logic [MAT_W-1:0]  work_next;
    logic              load;
    logic              issue;
    logic              issue_first;
    logic              issue_last;
    term_sel_t         sel;

    // pipeline
    logic                     s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    term_flags_t              s0_flags_reg, s1_flags_reg, s2_flags_reg, s3_flags_reg;
    term_flags_t              s0_flags_next;
    logic                     s0_last;
    logic signed [EB-1:0]     s0_e_reg, s0_a_reg, s0_b_reg, s0_c_reg;
    logic signed [EB-1:0]     s0_e_next, s0_a_next, s0_b_next, s0_c_next;
    logic signed [EB-1:0]     s1_b_reg, s1_c_reg, s2_c_reg;
    logic signed [2*EB-1:0]   s1_p_reg;
    logic signed [2*EB-1:0]   s1_p_next;
    logic signed [3*EB-1:0]   s2_p_reg;
    logic signed [3*EB-1:0]   s2_p_next;
    logic signed [4*EB-1:0]   s3_p_reg;
    logic signed [4*EB-1:0]   s3_p_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  term_ext;
    logic                     fin_reg;
    logic                     fin_next;
    logic                     done_reg;
    logic signed [DET_BITS-1:0] det_reg;
    logic signed [DET_BITS-1:0] det_next;

    assign sel         = term_select(row_reg, term_reg);
    assign issue_first = (row_reg == 2'd0) && (term_reg == 3'd0);
    assign issue_last  = (row_reg == ROW_LAST) && (term_reg == TERM_LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_stat.empty) state_next = BK_RUN;
            BK_RUN:  if (issue_last && q_stat.empty) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        load  = 1'b0;
        issue = 1'b0;
        unique case (state_reg)
            BK_IDLE: load = !q_stat.empty;
            BK_RUN:
            begin
                issue = 1'b1;
                load  = issue_last && !q_stat.empty;
            end
            default: load = 1'b0;
        endcase
    end

    assign q_pop = load;

    always_comb
    begin
        row_next  = row_reg;
        term_next = term_reg;
        if (load)
        begin
            row_next  = '0;
            term_next = '0;
        end
        else if (issue)
        begin
            if (term_reg == TERM_LAST)
            begin
                term_next = '0;
                row_next  = row_reg + 1'b1;
            end
            else
            begin
                term_next = term_reg + 1'b1;
            end
        end
    end

    assign work_next = load ? q_head : work_reg;

    // operand fetch, then one multiply per stage
    assign s0_e_next     = work_reg[EB*sel.e +: EB];
    assign s0_a_next     = work_reg[EB*sel.a +: EB];
    assign s0_b_next     = work_reg[EB*sel.b +: EB];
    assign s0_c_next     = work_reg[EB*sel.c +: EB];
    assign s0_flags_next = '{first: issue_first, last: issue_last, neg: sel.neg};
    assign s1_p_next     = s0_e_reg * s0_a_reg;
    assign s2_p_next     = s1_p_reg * s1_b_reg;
    assign s3_p_next     = s2_p_reg * s2_c_reg;
    assign s0_last       = s0_valid_reg && s0_flags_reg.last;

    always_comb
    begin
        acc_base = s3_flags_reg.first ? '0 : acc_reg;
        term_ext = ACC_W'(s3_p_reg);
        acc_next = acc_reg;
        if (s3_valid_reg)
        begin
            acc_next = s3_flags_reg.neg ? acc_base - term_ext : acc_base + term_ext;
        end
    end

    assign fin_next = s3_valid_reg && s3_flags_reg.last;

    // clamp to the result width
    always_comb
    begin
        det_next = det_reg;
        if (fin_reg)
        begin
            if (acc_reg > SAT_HI)
            begin
                det_next = SAT_HI[DET_BITS-1:0];
            end
            else if (acc_reg < SAT_LO)
            begin
                det_next = SAT_LO[DET_BITS-1:0];
            end
            else
            begin
                det_next = acc_reg[DET_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            row_reg      <= '0;
            term_reg     <= '0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            fin_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            term_reg     <= term_next;
            s0_valid_reg <= issue;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            fin_reg      <= fin_next;
            done_reg     <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        s0_e_reg     <= s0_e_next;
        s0_a_reg     <= s0_a_next;
        s0_b_reg     <= s0_b_next;
        s0_c_reg     <= s0_c_next;
        s0_flags_reg <= s0_flags_next;
        s1_p_reg     <= s1_p_next;
        s1_b_reg     <= s0_b_reg;
        s1_c_reg     <= s0_c_reg;
        s1_flags_reg <= s0_flags_reg;
        s2_p_reg     <= s2_p_next;
        s2_c_reg     <= s1_c_reg;
        s2_flags_reg <= s1_flags_reg;
        s3_p_reg     <= s3_p_next;
        s3_flags_reg <= s2_flags_reg;
        acc_reg      <= acc_next;
        det_reg      <= det_next;
    end

    assign done        = done_reg;
    assign determinant = det_reg;

    `DET4_ASSERT_NXT(a_done_single, done_reg, !done_reg, "result strobe held two cycles")
    `DET4_ASSERT_IMP(a_done_source, done_reg, $past(fin_reg), "strobe without closing term")
    `DET4_ASSERT_NXT(a_issue_last, issue && issue_last, s0_last, "closing term not issued")

endmodule

>>> rtl/core/determinant_4x4_core.sv
// Top level of the exact 4x4 determinant core: front end, matrix queue,
// back end. Depends on det4_pkg and the det4_front/queue/back modules.
//
// Feed the sixteen entries of a 4x4 signed matrix in row-major order, one
// word per cycle: a word is taken at each clock edge with start high and
// busy low. On the sixteenth word the matrix moves into a two-slot queue and
// the entry count returns to zero, so loading of the next matrix goes on at
// once. The back end issues the 24 four-factor terms of a matrix, one per
// cycle through a chain of three registered multipliers into an accumulator,
// and takes the next queued matrix while it issues the closing term; the
// clamped sum is registered and shown on determinant with done high for one
// cycle only. There is no back-pressure on results: capture them when done is
// high. busy rises only on a sixteenth word while both queue slots are full.
// The result is exact; with 13-bit entries it clamps to the 50-bit range.
module determinant_4x4_core #(
    parameter int ELEMENT_BITS = det4_pkg::ELEMENT_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [ELEMENT_BITS-1:0]       element,
    output logic                                 done,
    output logic signed [det4_pkg::DET_BITS-1:0] determinant
);
    import det4_pkg::*;

    localparam int MAT_W = ENTRIES * ELEMENT_BITS;

    q_stat_t          q_stat;
    logic             q_push;
    logic             q_pop;
    logic [MAT_W-1:0] q_data;
    logic [MAT_W-1:0] q_head;

    // gather words into a full matrix
    det4_front #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .element (element),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_data  (q_data)
    );

    // hold up to two finished matrices
    det4_queue #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .data_in (q_data),
        .pop     (q_pop),
        .head    (q_head),
        .stat    (q_stat)
    );

    // evaluate by cofactor expansion down the first column
    det4_back #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .done        (done),
        .determinant (determinant)
    );

endmodule
